// File: sv/tlms_pkg.sv
// Shared types and constants for the turn-limited move step block.
// No dependencies; imported by tlms_apb_regs, turn_limited_move_step and tb.
package tlms_pkg;

  localparam int SPEED_W = 24;
  localparam int RATE_W  = 16;
  localparam int CORDIC_STEPS = 24;

  // Angles are Q3.24 radians
  localparam logic signed [31:0] ANG_PI      = 32'sd52707179;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd26353589;
  localparam logic signed [35:0] GAIN_INV    = 36'sd652032875;

  typedef enum logic {
    REG_MOVE_SPEED = 1'b0,
    REG_TURN_RATE  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SPEED_W-1:0] move_speed;
    logic [RATE_W-1:0]  turn_rate;
  } tlms_cfg_t;

  function automatic logic [23:0] atan_lut(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/turn_limited_move_step.sv
// Turn-limited move step: heading steering with a shared multiplier, CORDIC,
// square-root and divider unit under one sequencer. Depends on tlms_pkg, tlms_apb_regs.
//
//  port group     dir  beat condition                 payload
//  config (APB)   in   psel & penable & pwrite        pwdata at paddr
//  tick input     in   in_valid_i & !in_stall_o       pos, dest, delta_time
//  result         out  out_valid_o & !out_stall_i     new_pos, moving, heading
//
// An item at the destination goes straight to the output state. Otherwise an advance
// and a turn are paced by the bit-serial normalize (one shift per cycle), 31-step square
// root, two 15-step divisions and the 24-step CORDIC, run once (advance) or twice with a
// second normalize (turn).
// Reset points the heading along +x and clears both registers.
// The input is stalled from acceptance until the result is in the output register;
// a waiting result does not block the next item.
module turn_limited_move_step import tlms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] dest_x_i,
  input  logic signed [31:0] dest_y_i,
  input  logic [15:0]        delta_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic               moving_o,
  output logic signed [15:0] heading_x_o,
  output logic signed [15:0] heading_y_o
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_NORM = 12'b000000000010,
    ST_SQ   = 12'b000000000100,
    ST_SQRT = 12'b000000001000,
    ST_DIV  = 12'b000000010000,
    ST_DOT  = 12'b000000100000,
    ST_ATAN = 12'b000001000000,
    ST_LIM  = 12'b000010000000,
    ST_CSIN = 12'b000100000000,
    ST_ROT  = 12'b001000000000,
    ST_ADV  = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_e;

  tlms_cfg_t cfg;

  tlms_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q;
  logic [5:0] cnt_q;

  logic signed [31:0] px_q, py_q, qx_q, qy_q;
  logic [15:0]        dt_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [15:0] hx_q, hy_q, ux_q, uy_q;

  logic [49:0]        nax_q, nay_q;
  logic               vneg_x_q, vneg_y_q, uni_ret_q;
  logic [61:0]        sq_q;
  logic [30:0]        len_q;
  logic [34:0]        rem_q;
  logic [14:0]        dlow_q, quo_q, qsav_q;

  logic signed [35:0] cx_q, cy_q;
  logic signed [31:0] cz_q, diff_q;
  logic               flip_q;

  logic signed [49:0] acc_x_q, acc_y_q;
  logic [24:0]        step_q;
  logic [64:0]        lft_q;
  logic               arrive_q;
  logic signed [65:0] prod_q;

  logic signed [31:0] res_x_q, res_y_q;
  logic               res_mv_q;

  logic               out_valid_q, out_mv_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic signed [15:0] out_hx_q, out_hy_q;

  function automatic logic signed [32:0] s16(input logic signed [15:0] v);
    return $signed({{17{v[15]}}, v});
  endfunction

  function automatic logic signed [32:0] u32(input logic [31:0] v);
    return $signed({1'b0, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Shared multiplier, registered every cycle
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = (cnt_q == 6'd0) ? $signed({3'b0, nax_q[29:0]}) : $signed({3'b0, nay_q[29:0]});
        mul_b = mul_a;
      end
      ST_DOT: begin
        case (cnt_q)
          6'd0: begin mul_a = s16(hx_q); mul_b = s16(ux_q); end
          6'd1: begin mul_a = s16(hy_q); mul_b = s16(uy_q); end
          6'd2: begin mul_a = s16(hx_q); mul_b = s16(uy_q); end
          6'd3: begin mul_a = s16(hy_q); mul_b = s16(ux_q); end
          default: ;
        endcase
      end
      ST_LIM: begin
        mul_a = u32({16'b0, cfg.turn_rate});
        mul_b = u32({16'b0, dt_q});
      end
      ST_ROT: begin
        case (cnt_q)
          6'd0: begin mul_a = s16(hx_q); mul_b = cx_q[32:0]; end
          6'd1: begin mul_a = s16(hy_q); mul_b = cy_q[32:0]; end
          6'd2: begin mul_a = s16(hx_q); mul_b = cy_q[32:0]; end
          6'd3: begin mul_a = s16(hy_q); mul_b = cx_q[32:0]; end
          default: ;
        endcase
      end
      ST_ADV: begin
        case (cnt_q)
          6'd0: begin mul_a = u32({8'b0, cfg.move_speed}); mul_b = u32({16'b0, dt_q}); end
          6'd1: begin
            mul_a = u32(dx_q[32] ? 32'(-dx_q) : dx_q[31:0]);
            mul_b = mul_a;
          end
          6'd2: begin
            mul_a = u32(dy_q[32] ? 32'(-dy_q) : dy_q[31:0]);
            mul_b = mul_a;
          end
          6'd3: begin mul_a = u32({7'b0, step_q}); mul_b = mul_a; end
          6'd4: begin mul_a = s16(ux_q); mul_b = u32({7'b0, step_q}); end
          6'd5: begin mul_a = s16(uy_q); mul_b = u32({7'b0, step_q}); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // CORDIC step, vectoring in ST_ATAN and rotation in ST_CSIN
  logic signed [35:0] xs, ys, cx_n, cy_n;
  logic signed [31:0] tval, cz_n;
  logic               dir_pos;

  assign xs      = cx_q >>> cnt_q[4:0];
  assign ys      = cy_q >>> cnt_q[4:0];
  assign tval    = $signed({8'b0, atan_lut(cnt_q[4:0])});
  assign dir_pos = (state_q == ST_ATAN) ? (cy_q <= 36'sd0) : (cz_q >= 32'sd0);
  assign cx_n    = dir_pos ? cx_q - ys : cx_q + ys;
  assign cy_n    = dir_pos ? cy_q + xs : cy_q - xs;
  assign cz_n    = dir_pos ? cz_q - tval : cz_q + tval;

  // Unit-vector helpers
  logic [49:0] mag_m;
  assign mag_m = (nax_q > nay_q) ? nax_q : nay_q;

  logic [34:0] sq_rem, sq_trial;
  assign sq_rem   = {rem_q[32:0], sq_q[61:60]};
  assign sq_trial = {2'b0, len_q, 2'b01};

  logic [29:0] div_src;
  logic [44:0] div_num;
  logic [34:0] div_r2;
  logic        div_ge;
  assign div_src = (cnt_q == 6'd0) ? nax_q[29:0] : nay_q[29:0];
  assign div_num = {1'b0, div_src, 14'b0} + {15'b0, len_q[30:1]};
  assign div_r2  = {rem_q[33:0], dlow_q[14]};
  assign div_ge  = div_r2 >= {4'b0, len_q};

  logic signed [15:0] fin_x, fin_y;
  assign fin_x = vneg_x_q ? -$signed({1'b0, qsav_q}) : $signed({1'b0, qsav_q});
  assign fin_y = vneg_y_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  // Accept-side differences
  logic signed [32:0] in_dx, in_dy;
  logic [32:0]        in_adx, in_ady;
  assign in_dx  = {dest_x_i[31], dest_x_i} - {pos_x_i[31], pos_x_i};
  assign in_dy  = {dest_y_i[31], dest_y_i} - {pos_y_i[31], pos_y_i};
  assign in_adx = in_dx[32] ? 33'(-in_dx) : in_dx;
  assign in_ady = in_dy[32] ? 33'(-in_dy) : in_dy;

  // Rotated-vector magnitudes
  logic [49:0] acc_ax, acc_ay;
  assign acc_ax = acc_x_q[49] ? 50'(-acc_x_q) : acc_x_q;
  assign acc_ay = acc_y_q[49] ? 50'(-acc_y_q) : acc_y_q;

  // Turn limit and fold
  logic [27:0]        lim;
  logic signed [31:0] absd, ang;
  assign lim  = prod_q[31:4];
  assign absd = diff_q[31] ? -diff_q : diff_q;
  assign ang  = (diff_q > 32'sd0) ? $signed({4'b0, lim}) : -$signed({4'b0, lim});

  // Advance displacement
  logic signed [65:0] rnd;
  logic signed [33:0] disp_sum_x, disp_sum_y;
  assign rnd        = (prod_q + 66'sd8192) >>> 14;
  assign disp_sum_x = {{2{px_q[31]}}, px_q} + rnd[33:0];
  assign disp_sum_y = {{2{py_q[31]}}, py_q} + rnd[33:0];

  logic in_beat, out_beat, out_free;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_beat   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hx_q        <= 16'sd16384;
      hy_q        <= 16'sd0;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= mul_p;
      cnt_q  <= cnt_q + 6'd1;
      if (out_beat) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_beat) begin
            px_q <= pos_x_i;
            py_q <= pos_y_i;
            qx_q <= dest_x_i;
            qy_q <= dest_y_i;
            dt_q <= delta_time_i;
            dx_q <= in_dx;
            dy_q <= in_dy;
            res_x_q  <= pos_x_i;
            res_y_q  <= pos_y_i;
            res_mv_q <= 1'b0;
            nax_q    <= {17'b0, in_adx};
            nay_q    <= {17'b0, in_ady};
            vneg_x_q <= in_dx[32];
            vneg_y_q <= in_dy[32];
            uni_ret_q <= 1'b0;
            if (in_dx == 33'sd0 && in_dy == 33'sd0) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          cnt_q <= '0;
          if (mag_m == '0) begin
            // degenerate vector: unit +x
            if (uni_ret_q) begin
              hx_q     <= 16'sd16384;
              hy_q     <= 16'sd0;
              res_mv_q <= 1'b1;
              state_q  <= ST_OUT;
            end else begin
              ux_q    <= 16'sd16384;
              uy_q    <= 16'sd0;
              state_q <= ST_DOT;
            end
          end else if (mag_m[49:30] != '0) begin
            nax_q <= nax_q >> 1;
            nay_q <= nay_q >> 1;
          end else if (!mag_m[29]) begin
            nax_q <= nax_q << 1;
            nay_q <= nay_q << 1;
          end else begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (cnt_q == 6'd1) begin
            sq_q <= prod_q[61:0];
          end else if (cnt_q == 6'd2) begin
            sq_q    <= sq_q + prod_q[61:0];
            rem_q   <= '0;
            len_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_rem >= sq_trial) begin
            rem_q <= sq_rem - sq_trial;
            len_q <= {len_q[29:0], 1'b1};
          end else begin
            rem_q <= sq_rem;
            len_q <= {len_q[29:0], 1'b0};
          end
          sq_q <= sq_q << 2;
          if (cnt_q == 6'd30) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'd0 || cnt_q == 6'd16) begin
            // load the high part of the dividend, quotient fits 15 bits
            rem_q  <= {5'b0, div_num[44:15]};
            dlow_q <= div_num[14:0];
            quo_q  <= '0;
            if (cnt_q == 6'd16) begin
              qsav_q <= quo_q;
            end
          end else if (cnt_q == 6'd32) begin
            cnt_q <= '0;
            if (uni_ret_q) begin
              hx_q     <= fin_x;
              hy_q     <= fin_y;
              res_mv_q <= 1'b1;
              state_q  <= ST_OUT;
            end else begin
              ux_q    <= fin_x;
              uy_q    <= fin_y;
              state_q <= ST_DOT;
            end
          end else begin
            rem_q  <= div_ge ? div_r2 - {4'b0, len_q} : div_r2;
            quo_q  <= {quo_q[13:0], div_ge};
            dlow_q <= dlow_q << 1;
          end
        end
        ST_DOT: begin
          case (cnt_q)
            6'd1: acc_x_q <= prod_q[49:0];
            6'd2: acc_x_q <= acc_x_q + prod_q[49:0];
            6'd3: acc_y_q <= prod_q[49:0];
            6'd4: acc_y_q <= acc_y_q - prod_q[49:0];
            6'd5: begin
              cnt_q <= '0;
              if (acc_x_q == '0 && acc_y_q == '0) begin
                diff_q  <= '0;
                state_q <= ST_LIM;
              end else begin
                state_q <= ST_ATAN;
                if (acc_x_q < 50'sd0) begin
                  // pre-rotate by pi into the right half plane
                  cx_q <= -acc_x_q[35:0];
                  cy_q <= -acc_y_q[35:0];
                  cz_q <= (acc_y_q >= 50'sd0) ? ANG_PI : -ANG_PI;
                end else begin
                  cx_q <= acc_x_q[35:0];
                  cy_q <= acc_y_q[35:0];
                  cz_q <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        ST_ATAN: begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
            diff_q  <= cz_n;
            cnt_q   <= '0;
            state_q <= ST_LIM;
          end
        end
        ST_LIM: begin
          if (cnt_q == 6'd1) begin
            cnt_q <= '0;
            if (absd > $signed({4'b0, lim})) begin
              cx_q    <= GAIN_INV;
              cy_q    <= '0;
              state_q <= ST_CSIN;
              if (ang > ANG_HALF_PI) begin
                cz_q   <= ang - ANG_PI;
                flip_q <= 1'b1;
              end else if (ang < -ANG_HALF_PI) begin
                cz_q   <= ang + ANG_PI;
                flip_q <= 1'b1;
              end else begin
                cz_q   <= ang;
                flip_q <= 1'b0;
              end
            end else begin
              hx_q    <= ux_q;
              hy_q    <= uy_q;
              state_q <= ST_ADV;
            end
          end
        end
        ST_CSIN: begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
            cx_q    <= flip_q ? -cx_n : cx_n;
            cy_q    <= flip_q ? -cy_n : cy_n;
            cnt_q   <= '0;
            state_q <= ST_ROT;
          end
        end
        ST_ROT: begin
          case (cnt_q)
            6'd1: acc_x_q <= prod_q[49:0];
            6'd2: acc_x_q <= acc_x_q - prod_q[49:0];
            6'd3: acc_y_q <= prod_q[49:0];
            6'd4: acc_y_q <= acc_y_q + prod_q[49:0];
            6'd5: begin
              nax_q     <= acc_ax;
              nay_q     <= acc_ay;
              vneg_x_q  <= acc_x_q[49];
              vneg_y_q  <= acc_y_q[49];
              uni_ret_q <= 1'b1;
              cnt_q     <= '0;
              state_q   <= ST_NORM;
            end
            default: ;
          endcase
        end
        ST_ADV: begin
          case (cnt_q)
            6'd1: step_q <= 25'((prod_q[39:0] + 40'd32768) >> 16);
            6'd2: lft_q  <= {1'b0, prod_q[63:0]};
            6'd3: lft_q  <= lft_q + {1'b0, prod_q[63:0]};
            6'd4: arrive_q <= lft_q < {17'b0, prod_q[47:0]};
            6'd5: res_x_q  <= sat32(disp_sum_x);
            6'd6: begin
              cnt_q   <= '0;
              state_q <= ST_OUT;
              if (arrive_q) begin
                res_x_q  <= qx_q;
                res_y_q  <= qy_q;
                res_mv_q <= 1'b0;
              end else begin
                res_y_q  <= sat32(disp_sum_y);
                res_mv_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          cnt_q <= '0;
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_mv_q    <= res_mv_q;
            out_hx_q    <= hx_q;
            out_hy_q    <= hy_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_pos_x_o = out_x_q;
  assign new_pos_y_o = out_y_q;
  assign moving_o    = out_mv_q;
  assign heading_x_o = out_hx_q;
  assign heading_y_o = out_hy_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the output state");

  a_cordic_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ATAN || state_q == ST_CSIN) |-> (cnt_q < 6'(CORDIC_STEPS)))
    else $error("CORDIC step count overran");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (hx_q <= 16'sd16384 && hx_q >= -16'sd16384 &&
                            hy_q <= 16'sd16384 && hy_q >= -16'sd16384))
    else $error("heading left the unit range");

endmodule

// File: sv/tlms_apb_regs.sv
// APB configuration registers: move speed and turn rate.
// Depends on tlms_pkg.
module tlms_apb_regs import tlms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output tlms_cfg_t   cfg_o
);

  tlms_cfg_t cfg_q;
  reg_idx_e  idx;

  assign idx    = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_MOVE_SPEED: cfg_q.move_speed <= pwdata[SPEED_W-1:0];
        REG_TURN_RATE:  cfg_q.turn_rate  <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOVE_SPEED: prdata = {{(32-SPEED_W){1'b0}}, cfg_q.move_speed};
      REG_TURN_RATE:  prdata = {{(32-RATE_W){1'b0}}, cfg_q.turn_rate};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: verif/tb.sv
// Self-checking testbench for turn_limited_move_step: directed table then random ticks,
// each result checked against a bit-exact steering predictor or a typed expected value. Depends on tlms_pkg.
`timescale 1ns / 100ps

module tb import tlms_pkg::*; ();

  localparam int  IDLE_LIMIT = 20000;
  localparam int  HOLD_CYCLES = 3000;
  localparam int  RAND_PER_PHASE = 100;
  localparam logic [2:0] ADDR_SPEED = 3'(4 * REG_MOVE_SPEED);
  localparam logic [2:0] ADDR_RATE  = 3'(4 * REG_TURN_RATE);
  localparam longint ATAN_Q24 [CORDIC_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic signed [31:0] px, py, qx, qy;
    logic [15:0]        dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] nx, ny;
    logic               moving;
    logic signed [15:0] hx, hy;
  } move_t;

  typedef struct {
    logic        set_cfg;
    logic [23:0] speed;
    logic [15:0] rate;
    tick_t       tick;
    logic        typed;
    move_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  tick_t drv = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  move_t got;

  // predictor state
  logic [23:0] cfg_speed;
  logic [15:0] cfg_rate;
  logic signed [15:0] head_x, head_y;

  move_t pending_moves[$];
  int errors = 0;
  logic hold_req = 1'b0;

  turn_limited_move_step dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(drv.px), .pos_y_i(drv.py), .dest_x_i(drv.qx), .dest_y_i(drv.qy),
    .delta_time_i(drv.dt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_pos_x_o(got.nx), .new_pos_y_o(got.ny), .moving_o(got.moving),
    .heading_x_o(got.hx), .heading_y_o(got.hy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void to_unit(input longint vx, input longint vy,
                                  output logic signed [15:0] ox,
                                  output logic signed [15:0] oy);
    longint unsigned ax, ay, m, len, ux, uy;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    m = ax > ay ? ax : ay;
    if (m == 0) begin
      ox = 16384;
      oy = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    len = root64(ax * ax + ay * ay);
    ux = (ax * 16384 + len / 2) / len;
    uy = (ay * 16384 + len / 2) / len;
    ox = vx < 0 ? -16'(ux) : 16'(ux);
    oy = vy < 0 ? -16'(uy) : 16'(uy);
  endfunction

  // atan2(y, x) in Q3.24 by vectoring
  function automatic longint heading_delta(input longint x, input longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = y >= 0 ? longint'(ANG_PI) : -longint'(ANG_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_Q24[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q24[i];
      end
    end
    return z;
  endfunction

  function automatic void rot_cos_sin(input longint a, output longint c, output longint s);
    longint x, y, xs, ys;
    logic flip;
    x = GAIN_INV;
    y = 0;
    flip = 1'b0;
    if (a > longint'(ANG_HALF_PI)) begin
      a -= ANG_PI; flip = 1'b1;
    end else if (a < -longint'(ANG_HALF_PI)) begin
      a += ANG_PI; flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= ATAN_Q24[i];
      end else begin
        x += ys; y -= xs; a += ATAN_Q24[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic move_t steer_step(input tick_t t);
    move_t r;
    longint dx, dy, hx, hy, diff, lim, c, s, adiff;
    longint unsigned stp, ax, ay, sx, sy, left;
    logic signed [15:0] ux, uy;
    r.nx = t.px;
    r.ny = t.py;
    r.moving = 1'b0;
    if (t.px != t.qx || t.py != t.qy) begin
      dx = longint'(t.qx) - longint'(t.px);
      dy = longint'(t.qy) - longint'(t.py);
      hx = head_x;
      hy = head_y;
      r.moving = 1'b1;
      to_unit(dx, dy, ux, uy);
      diff = heading_delta(hx * ux + hy * uy, hx * uy - hy * ux);
      lim = (longint'(cfg_rate) * longint'(t.dt)) >> 4;
      adiff = diff < 0 ? -diff : diff;
      if (adiff > lim) begin
        rot_cos_sin(diff > 0 ? lim : -lim, c, s);
        to_unit(hx * c - hy * s, hx * s + hy * c, head_x, head_y);
      end else begin
        stp = (longint'(cfg_speed) * longint'(t.dt) + 32768) >> 16;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sx = ax * ax;
        sy = ay * ay;
        left = sx + sy;
        if (left < sx) left = '1;
        head_x = ux;
        head_y = uy;
        if (left >= stp * stp) begin
          r.nx = clamp32(longint'(t.px) + ((longint'(ux) * longint'(stp) + 8192) >>> 14));
          r.ny = clamp32(longint'(t.py) + ((longint'(uy) * longint'(stp) + 8192) >>> 14));
        end else begin
          r.nx = t.qx;
          r.ny = t.qy;
          r.moving = 1'b0;
        end
      end
    end
    r.hx = head_x;
    r.hy = head_y;
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drop valid, drain all results, then reprogram both registers
  task automatic set_limits(input logic [23:0] speed, input logic [15:0] rate);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write(ADDR_SPEED, 32'(speed));
    apb_write(ADDR_RATE, 32'(rate));
    cfg_speed = speed;
    cfg_rate = rate;
  endtask

  // offer one beat and hold it until taken; returns the predicted result
  task automatic send_tick(input tick_t t, input logic typed, input move_t want,
                           output move_t res);
    @(negedge clk);
    drv <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    res = steer_step(t);
    pending_moves.push_back(typed ? want : res);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (n != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] p);
    int k;
    k = $urandom_range(2, 26);
    return 32'(longint'(p) + longint'($urandom_range(0, (1 << k) - 1)) - (longint'(1) << (k - 1)));
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: switches among free-running, light and heavy stall patterns, plus one long hold-off
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    move_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_moves.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        errors++;
      end else begin
        w = pending_moves.pop_front();
        if (got.nx !== w.nx) begin
          $display("%0t: new_pos_x exp %0d got %0d", $time, w.nx, got.nx);
          errors++;
        end
        if (got.ny !== w.ny) begin
          $display("%0t: new_pos_y exp %0d got %0d", $time, w.ny, got.ny);
          errors++;
        end
        if (got.moving !== w.moving) begin
          $display("%0t: moving exp %0d got %0d", $time, w.moving, got.moving);
          errors++;
        end
        if (got.hx !== w.hx) begin
          $display("%0t: heading_x exp %0d got %0d", $time, w.hx, got.hx);
          errors++;
        end
        if (got.hy !== w.hy) begin
          $display("%0t: heading_y exp %0d got %0d", $time, w.hy, got.hy);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    move_t none, res;
    tick_t t, chain;
    int seq_left, burst;
    logic [23:0] speeds [6];
    logic [15:0] rates [6];

    none = '{default: '0};
    cfg_speed = '0;
    cfg_rate = '0;
    head_x = 16384;
    head_y = 0;

    // after reset: both limits zero
    rows.push_back('{1'b0, 24'd0, 16'd0, '{0, 0, 0, 0, 16'h0000}, 1'b1,
                     '{0, 0, 1'b0, 16'sd16384, 16'sd0}});
    rows.push_back('{1'b0, 24'd0, 16'd0, '{0, 0, 32'h10000, 0, 16'hffff}, 1'b1,
                     '{0, 0, 1'b1, 16'sd16384, 16'sd0}});
    rows.push_back('{1'b0, 24'd0, 16'd0,
                     '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'hffff},
                     1'b0, none});
    rows.push_back('{1'b0, 24'd0, 16'd0, '{0, 0, -1, 0, 16'h1234}, 1'b0, none});
    rows.push_back('{1'b0, 24'd0, 16'd0, '{0, 0, 0, -65536, 16'h0000}, 1'b0, none});
    // fastest limits: snap and arrive, then saturate at the edges
    rows.push_back('{1'b1, 24'hffffff, 16'hffff, '{0, 0, 1, 0, 16'hffff}, 1'b0, none});
    rows.push_back('{1'b0, 24'hffffff, 16'hffff,
                     '{32'sh7fff0000, 32'sh7fff0000, 32'sh7fffffff, 32'sh80000000, 16'hffff},
                     1'b0, none});
    rows.push_back('{1'b0, 24'hffffff, 16'hffff,
                     '{32'sh80000001, 0, 32'sh80000000, 0, 16'hffff}, 1'b0, none});
    rows.push_back('{1'b0, 24'hffffff, 16'hffff,
                     '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'h8000},
                     1'b0, none});
    rows.push_back('{1'b0, 24'hffffff, 16'hffff,
                     '{0, 0, 32'sh7fffffff, 32'sh7fffffff, 16'h0000}, 1'b0, none});
    // slowest turn: heading creeps around toward a target behind
    rows.push_back('{1'b1, 24'h010000, 16'h0001, '{0, 0, -65536, 0, 16'hffff}, 1'b0, none});
    rows.push_back('{1'b0, 24'h010000, 16'h0001, '{0, 0, 0, 65536, 16'hffff}, 1'b0, none});
    rows.push_back('{1'b0, 24'h010000, 16'h0001, '{5, 7, 5, -9, 16'h0001}, 1'b0, none});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].set_cfg) set_limits(rows[i].speed, rows[i].rate);
      send_tick(rows[i].tick, rows[i].typed, rows[i].want, res);
    end

    speeds = '{24'hffffff, 24'd0, 24'h010000, 24'($urandom), 24'h400000, 24'($urandom)};
    rates  = '{16'hffff, 16'd0, 16'h0100, 16'($urandom), 16'h0004, 16'($urandom)};
    seq_left = 0;
    chain = '{default: '0};
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(speeds[ph], rates[ph]);
      burst = 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 3 && n == 10) hold_req = 1'b1;
        t.px = 32'($urandom);
        t.py = 32'($urandom);
        t.dt = pick_dt();
        case ($urandom_range(0, 9))
          0: begin
            t.qx = t.px;
            t.qy = t.py;
          end
          1, 2, 3, 4: begin
            // steering run: feed each new position back in until arrival or the end of the run
            if (seq_left == 0) begin
              chain.px = near(0);
              chain.py = near(0);
              chain.qx = near(chain.px);
              chain.qy = near(chain.py);
              seq_left = $urandom_range(5, 30);
            end
            seq_left--;
            t.px = chain.px; t.py = chain.py; t.qx = chain.qx; t.qy = chain.qy;
          end
          5, 6: begin
            t.qx = near(t.px);
            t.qy = near(t.py);
          end
          7: begin
            t.px = $urandom_range(0, 1) ? 32'sh7fffffff - 32'($urandom_range(0, 1 << 20))
                                        : 32'sh80000000 + 32'($urandom_range(0, 1 << 20));
            t.qx = t.px[31] ? 32'sh80000000 : 32'sh7fffffff;
            t.qy = near(t.py);
          end
          default: begin
            t.qx = 32'($urandom);
            t.qy = 32'($urandom);
          end
        endcase
        send_tick(t, 1'b0, none, res);
        chain.px = res.nx;
        chain.py = res.ny;
        if (!res.moving) seq_left = 0;
        if (burst == 0) begin
          idle_gap();
          burst = $urandom_range(1, 20);
        end
        burst--;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
